// File: design/lle_pkg.sv
// Shared constants, codes and controller/datapath interface types for the linked list engine.
package lle_pkg;

    localparam int DEPTH  = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int CMD_W  = 3;
    localparam int ST_W   = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_HEAD = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_TAIL = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_POS  = 3'd5;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

    // Controller to datapath strobes
    typedef struct packed {
        logic load;
        logic pre_ins;
        logic pre_del;
        logic walk;
        logic ins_alloc;
        logic ins_link;
        logic ins_splice;
        logic del_head;
        logic del_pred;
        logic del_unlink;
        logic del_free;
        logic emit;
    } lle_cmd_t;

    // Datapath to controller flags
    typedef struct packed {
        logic err;
        logic is_ins;
        logic pos_zero;
        logic pos_one;
        logic at_end;
        logic steps_one;
        logic out_free;
    } lle_stat_t;

endpackage

// File: design/linked_list_engine.sv
// Linked list engine: one result beat per command beat over a 32-node pool.
// Steps: an error goes straight to the result; a head insert allocates a node; a head delete
// unlinks and frees the head; an end insert allocates, links and splices; other operations at
// position p walk p - 1 links, one link read per cycle. One command at a time; next beat taken once result registered.
// Reset (aresetn low, synchronous): list empty, free chain in pool order, no result pending.
// Node values need no clearing; link entries read as the free chain until written.
module linked_list_engine import lle_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[5:0], value[37:6], zero[39:38]
    input  logic [7:0]  s_tuser,   // command[2:0], zero[7:3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // removed_value[31:0], length[37:32], zero[39:38]
    output logic [7:0]  m_tuser    // status[1:0], zero[7:2]
);

    lle_cmd_t          cmd;
    lle_stat_t         stat;
    logic [ST_W-1:0]   out_status;
    logic [DATA_W-1:0] out_removed;
    logic [CNT_W-1:0]  out_length;

    lle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lle_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_command  (s_tuser[CMD_W-1:0]),
        .in_position (s_tdata[POS_W-1:0]),
        .in_value    (s_tdata[POS_W+DATA_W-1:POS_W]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_status  (out_status),
        .out_removed (out_removed),
        .out_length  (out_length)
    );

    // Pack result beat
    assign m_tdata = {2'b00, out_length, out_removed};
    assign m_tuser = {6'b000000, out_status};

`ifndef NO_ASSERTIONS
    // A command beat is never followed by another in the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while command in progress");

    // Length never exceeds the pool size
    a_length_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[37:32] <= 6'(DEPTH)))
        else $error("length beyond pool size");

    // Failed commands remove nothing
    a_removed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[1:0] != ST_OK)) |-> (m_tdata[31:0] == '0))
        else $error("removed value on failed command");

    // Empty status only on an empty list
    a_empty_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[1:0] == ST_EMPTY)) |-> (m_tdata[37:32] == '0))
        else $error("empty status with nonzero length");
`endif

endmodule

// File: design/lle_ctrl.sv
// Sequencing state machine for list commands.
module lle_ctrl import lle_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  lle_stat_t stat,
    output lle_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_PRE        = 4'd1;
    localparam logic [3:0] S_WALK       = 4'd2;
    localparam logic [3:0] S_INS_ALLOC  = 4'd3;
    localparam logic [3:0] S_INS_LINK   = 4'd4;
    localparam logic [3:0] S_INS_SPLICE = 4'd5;
    localparam logic [3:0] S_DEL_HEAD   = 4'd6;
    localparam logic [3:0] S_DEL_PRED   = 4'd7;
    localparam logic [3:0] S_DEL_UNLINK = 4'd8;
    localparam logic [3:0] S_DEL_FREE   = 4'd9;
    localparam logic [3:0] S_DONE       = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // Next state and datapath strobes
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_PRE;
                end
            end
            S_PRE: begin
                if (stat.err) begin
                    state_next = S_DONE;
                end else if (stat.is_ins) begin
                    cmd.pre_ins = 1'b1;
                    state_next  = S_INS_ALLOC;
                end else begin
                    cmd.pre_del = 1'b1;
                    if (stat.pos_zero) begin
                        state_next = S_DEL_HEAD;
                    end else if (stat.pos_one) begin
                        state_next = S_DEL_PRED;
                    end else begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK: begin
                cmd.walk = 1'b1;
                if (stat.steps_one) begin
                    state_next = stat.is_ins ? S_INS_LINK : S_DEL_PRED;
                end
            end
            S_INS_ALLOC: begin
                cmd.ins_alloc = 1'b1;
                if (stat.pos_zero) begin
                    state_next = S_DONE;
                end else if (stat.at_end || stat.pos_one) begin
                    state_next = S_INS_LINK;
                end else begin
                    state_next = S_WALK;
                end
            end
            S_INS_LINK: begin
                cmd.ins_link = 1'b1;
                state_next   = S_INS_SPLICE;
            end
            S_INS_SPLICE: begin
                cmd.ins_splice = 1'b1;
                state_next     = S_DONE;
            end
            S_DEL_HEAD: begin
                cmd.del_head = 1'b1;
                state_next   = S_DEL_FREE;
            end
            S_DEL_PRED: begin
                cmd.del_pred = 1'b1;
                state_next   = S_DEL_UNLINK;
            end
            S_DEL_UNLINK: begin
                cmd.del_unlink = 1'b1;
                state_next     = S_DEL_FREE;
            end
            S_DEL_FREE: begin
                cmd.del_free = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/lle_datapath.sv
// Node pool memories, list pointers, command decode and result register.
module lle_datapath import lle_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  lle_cmd_t          cmd,
    output lle_stat_t         stat,
    input  logic [CMD_W-1:0]  in_command,
    input  logic [POS_W-1:0]  in_position,
    input  logic [DATA_W-1:0] in_value,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [ST_W-1:0]   out_status,
    output logic [DATA_W-1:0] out_removed,
    output logic [CNT_W-1:0]  out_length
);

    // List pointers and counters
    logic [IDX_W-1:0]  head_reg, tail_reg, free_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  cur_reg, node_reg;
    logic [POS_W-1:0]  pos_reg, steps_reg;
    logic [DATA_W-1:0] val_reg, removed_reg;
    logic [ST_W-1:0]   st_reg;
    logic              is_ins_reg, at_end_reg;

    // Result register
    logic              m_tvalid_reg;
    logic [ST_W-1:0]   m_st_reg;
    logic [DATA_W-1:0] m_rem_reg;
    logic [CNT_W-1:0]  m_len_reg;

    // Link memory with per-entry written flags
    logic [IDX_W-1:0]  link_mem [DEPTH];
    logic [DEPTH-1:0]  link_vld_reg;
    logic [IDX_W-1:0]  link_q_reg, link_ra_reg;
    logic              link_vq_reg;
    logic              link_re, link_we;
    logic [IDX_W-1:0]  link_ra, link_wa, link_wd, link_rd;

    // Value memory
    logic [DATA_W-1:0] val_mem [DEPTH];
    logic [DATA_W-1:0] val_q_reg;
    logic              val_re;
    logic [IDX_W-1:0]  val_ra;

    // Command decode
    logic [POS_W-1:0]  cnt_pos, p_in;
    logic [ST_W-1:0]   st_in;
    logic              ins_in, at_end_in;

    assign cnt_pos = POS_W'(count_reg);

    // Normalize position and check it against the list length
    always_comb begin
        p_in      = in_position;
        st_in     = ST_OK;
        ins_in    = 1'b0;
        at_end_in = 1'b0;
        unique case (in_command) inside
            CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
                ins_in = 1'b1;
                if (in_command == CMD_INS_HEAD) begin
                    p_in = '0;
                end else if (in_command == CMD_INS_TAIL) begin
                    p_in = cnt_pos;
                end
                at_end_in = (p_in == cnt_pos);
                if (count_reg == CNT_W'(DEPTH)) begin
                    st_in = ST_FULL;
                end else if (p_in > cnt_pos) begin
                    st_in = ST_BADPOS;
                end
            end
            CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_POS: begin
                if (in_command == CMD_DEL_HEAD) begin
                    p_in = '0;
                end else if (in_command == CMD_DEL_TAIL) begin
                    p_in = cnt_pos - POS_W'(1);
                end
                at_end_in = (p_in == cnt_pos - POS_W'(1));
                if (count_reg == '0) begin
                    st_in = ST_EMPTY;
                end else if (p_in >= cnt_pos) begin
                    st_in = ST_BADPOS;
                end
            end
            default: begin
                st_in = ST_BADPOS;
            end
        endcase
    end

    // Link read data: unwritten entries hold the initial free chain
    assign link_rd = link_vq_reg ? link_q_reg
                   : ((link_ra_reg == IDX_W'(DEPTH - 1)) ? '0 : link_ra_reg + IDX_W'(1));

    // Link memory port selection
    always_comb begin
        link_re = 1'b0;
        link_ra = head_reg;
        link_we = 1'b0;
        link_wa = node_reg;
        link_wd = free_reg;
        if (cmd.pre_ins) begin
            link_re = 1'b1;
            link_ra = free_reg;
        end
        if (cmd.pre_del) begin
            link_re = 1'b1;
            link_ra = head_reg;
        end
        if (cmd.walk || cmd.del_pred) begin
            link_re = 1'b1;
            link_ra = link_rd;
        end
        if (cmd.ins_alloc) begin
            if (stat.pos_zero) begin
                link_we = 1'b1;
                link_wa = free_reg;
                link_wd = head_reg;
            end else begin
                link_re = 1'b1;
                link_ra = at_end_reg ? tail_reg : head_reg;
            end
        end
        if (cmd.ins_link) begin
            link_we = 1'b1;
            link_wa = node_reg;
            link_wd = link_rd;
        end
        if (cmd.ins_splice) begin
            link_we = 1'b1;
            link_wa = cur_reg;
            link_wd = node_reg;
        end
        if (cmd.del_unlink) begin
            link_we = 1'b1;
            link_wa = cur_reg;
            link_wd = link_rd;
        end
        if (cmd.del_free) begin
            link_we = 1'b1;
            link_wa = node_reg;
            link_wd = free_reg;
        end
    end

    assign val_re = cmd.pre_del || cmd.del_pred;
    assign val_ra = cmd.del_pred ? link_rd : head_reg;

    // Link memory access
    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        if (link_re) begin
            link_q_reg  <= link_mem[link_ra];
            link_ra_reg <= link_ra;
        end
    end

    // Value memory access
    always_ff @(posedge aclk) begin
        if (cmd.ins_alloc) begin
            val_mem[free_reg] <= val_reg;
        end
        if (val_re) begin
            val_q_reg <= val_mem[val_ra];
        end
    end

    // Control state: pointers, count, written flags, result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            free_reg     <= '0;
            count_reg    <= '0;
            link_vld_reg <= '0;
            link_vq_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (link_we) begin
                link_vld_reg[link_wa] <= 1'b1;
            end
            if (link_re) begin
                link_vq_reg <= link_vld_reg[link_ra];
            end
            if (cmd.ins_alloc) begin
                free_reg <= link_rd;
                if (stat.pos_zero) begin
                    head_reg  <= free_reg;
                    count_reg <= count_reg + CNT_W'(1);
                    if (count_reg == '0) begin
                        tail_reg <= free_reg;
                    end
                end
            end
            if (cmd.ins_link && at_end_reg) begin
                tail_reg <= node_reg;
            end
            if (cmd.ins_splice) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.del_head) begin
                head_reg <= link_rd;
                if (count_reg == CNT_W'(1)) begin
                    tail_reg <= link_rd;
                end
            end
            if (cmd.del_unlink && at_end_reg) begin
                tail_reg <= cur_reg;
            end
            if (cmd.del_free) begin
                free_reg  <= node_reg;
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pos_reg     <= p_in;
            val_reg     <= in_value;
            st_reg      <= st_in;
            is_ins_reg  <= ins_in;
            at_end_reg  <= at_end_in;
            removed_reg <= '0;
        end
        if (cmd.pre_del) begin
            cur_reg   <= head_reg;
            steps_reg <= pos_reg - POS_W'(1);
        end
        if (cmd.walk) begin
            cur_reg   <= link_rd;
            steps_reg <= steps_reg - POS_W'(1);
        end
        if (cmd.ins_alloc) begin
            node_reg <= free_reg;
            cur_reg  <= at_end_reg ? tail_reg : head_reg;
            steps_reg <= pos_reg - POS_W'(1);
        end
        if (cmd.del_head) begin
            node_reg <= head_reg;
        end
        if (cmd.del_pred) begin
            node_reg <= link_rd;
        end
        if (cmd.del_free) begin
            removed_reg <= val_q_reg;
        end
        if (cmd.emit) begin
            m_st_reg  <= st_reg;
            m_rem_reg <= removed_reg;
            m_len_reg <= count_reg;
        end
    end

    // Flags to the controller
    assign stat.err       = (st_reg != ST_OK);
    assign stat.is_ins    = is_ins_reg;
    assign stat.pos_zero  = (pos_reg == '0);
    assign stat.pos_one   = (pos_reg == POS_W'(1));
    assign stat.at_end    = at_end_reg;
    assign stat.steps_one = (steps_reg == POS_W'(1));
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid    = m_tvalid_reg;
    assign out_status  = m_st_reg;
    assign out_removed = m_rem_reg;
    assign out_length  = m_len_reg;

endmodule

// File: verif/linked_list_engine_test.sv
// Self-checking testbench for the linked list engine: random and directed list commands.
module linked_list_engine_test;
    import lle_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int PHASE_ITEMS    = 390;
    localparam int PRESSURE_ITEMS = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 20000;

    // Command codes the block does not define; both must answer bad position
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    // Stimulus modes for the random part
    typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} list_mode_t;

    // One expected result beat
    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [DATA_W-1:0] removed;
        logic [CNT_W-1:0]  length;
    } list_answer_t;

    // Tracks list contents and the answers still owed by the block
    class list_scoreboard;
        logic [DATA_W-1:0] list_vals[$];
        list_answer_t      answers[$];
        int                errors;
        int                commands;
        int                results;
        int                status_seen[4];
        int                deepest;

        function int unsigned length();
            return list_vals.size();
        endfunction

        function int unsigned pending();
            return answers.size();
        endfunction

        // Apply one accepted command to the list and queue its answer
        function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                   logic [DATA_W-1:0] val);
            list_answer_t a;
            int unsigned  n;
            int unsigned  p;
            n = list_vals.size();
            a.status = ST_OK;
            a.removed = '0;
            p = 0;
            case (cmd)
                CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
                    if (cmd == CMD_INS_TAIL) p = n;
                    else if (cmd == CMD_INS_POS) p = pos;
                    if (n >= DEPTH) a.status = ST_FULL;
                    else if (p > n) a.status = ST_BADPOS;
                    else list_vals.insert(p, val);
                end
                CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_POS: begin
                    if (cmd == CMD_DEL_TAIL) p = (n != 0) ? n - 1 : 0;
                    else if (cmd == CMD_DEL_POS) p = pos;
                    if (n == 0) a.status = ST_EMPTY;
                    else if (p >= n) a.status = ST_BADPOS;
                    else begin
                        a.removed = list_vals[p];
                        list_vals.delete(p);
                    end
                end
                default: a.status = ST_BADPOS;
            endcase
            a.length = CNT_W'(list_vals.size());
            if (list_vals.size() > deepest) deepest = list_vals.size();
            answers.push_back(a);
            commands++;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one result beat with the oldest answer
        task check_result(logic [ST_W-1:0] st, logic [DATA_W-1:0] rv, logic [CNT_W-1:0] len);
            list_answer_t a;
            results++;
            if (answers.size() == 0) begin
                report($sformatf("result beat with no command pending (status %0d)", st));
                return;
            end
            a = answers.pop_front();
            status_seen[a.status]++;
            if (st !== a.status)
                report($sformatf("result %0d: status %0d, want %0d", results, st, a.status));
            if (rv !== a.removed)
                report($sformatf("result %0d: removed %h, want %h", results, rv, a.removed));
            if (len !== a.length)
                report($sformatf("result %0d: length %0d, want %0d", results, len, a.length));
        endtask

        task drain_check();
            if (answers.size() != 0)
                report($sformatf("%0d results never arrived", answers.size()));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // position[5:0], value[37:6], zero[39:38]
    logic [7:0]  s_tuser;   // command[2:0], zero[7:3]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // removed_value[31:0], length[37:32], zero[39:38]
    logic [7:0]  m_tuser;   // status[1:0], zero[7:2]

    list_scoreboard sb = new();
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_req;
    bit  hold_served;
    int  hold_count;
    int  quiet_cycles;

    linked_list_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    // Watch both channels at the rising edge; end the run if nothing moves
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_command(s_tuser[CMD_W-1:0], s_tdata[POS_W-1:0],
                                s_tdata[POS_W+DATA_W-1:POS_W]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser[ST_W-1:0], m_tdata[DATA_W-1:0],
                                m_tdata[DATA_W+CNT_W-1:DATA_W]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off counted here
    initial begin
        m_tready = 1'b0;
        hold_served = 1'b0;
        hold_count = 0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_served) begin
                m_tready <= 1'b0;
                hold_count++;
                if (hold_count == HOLD_CYCLES) hold_served = 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Offer one command beat and hold it until accepted; entered and left at a falling edge
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                            input logic [DATA_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, val, pos};
        s_tuser  <= {5'b00000, cmd};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Random commands in stretches that grow, shrink or churn the list
    task automatic send_random(input int count);
        list_mode_t        mode;
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        int unsigned       n;
        int                r;
        int                ins_pct;
        bit                is_ins;
        mode = MODE_MIXED;
        for (int i = 0; i < count; i++) begin
            if (i % 48 == 0) mode = list_mode_t'($urandom_range(0, 2));
            ins_pct = (mode == MODE_GROW) ? 80 : (mode == MODE_SHRINK) ? 25 : 52;
            n = sb.length();
            r = $urandom_range(0, 99);
            is_ins = (r < ins_pct);
            if (r >= 97)
                cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
            else if (is_ins)
                cmd = CMD_INS_HEAD + CMD_W'($urandom_range(0, 2));
            else
                cmd = CMD_DEL_HEAD + CMD_W'($urandom_range(0, 2));
            // Mostly legal positions, some at the end, some anywhere in the field
            r = $urandom_range(0, 9);
            if (r <= 5)
                pos = is_ins ? POS_W'($urandom_range(0, n))
                             : ((n != 0) ? POS_W'($urandom_range(0, n - 1)) : '0);
            else if (r == 6)
                pos = is_ins ? POS_W'(n) : ((n != 0) ? POS_W'(n - 1) : '0);
            else if (r == 7)
                pos = '0;
            else
                pos = POS_W'($urandom_range(0, 63));
            case ($urandom_range(0, 15))
                0:       val = '0;
                1:       val = 32'h8000_0000;
                2:       val = 32'h7FFF_FFFF;
                3:       val = '1;
                default: val = $urandom();
            endcase
            send_cmd(cmd, pos, val);
        end
    endtask

    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        aresetn = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        quiet_cycles = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Deletes from an empty list, insert past the end of an empty list
        send_cmd(CMD_DEL_HEAD, 6'd0, 32'h0);
        send_cmd(CMD_DEL_TAIL, 6'd0, 32'h0);
        send_cmd(CMD_DEL_POS, 6'd0, 32'h0);
        send_cmd(CMD_INS_POS, 6'd1, 32'h1234_5678);
        // Build a short list with extreme values
        send_cmd(CMD_INS_POS, 6'd0, 32'h8000_0000);
        send_cmd(CMD_INS_TAIL, 6'd0, 32'h7FFF_FFFF);
        send_cmd(CMD_INS_HEAD, 6'd63, 32'hFFFF_FFFF);
        send_cmd(CMD_INS_POS, 6'd3, 32'h0000_0000);
        // Positions past the end and undefined commands
        send_cmd(CMD_INS_POS, 6'd63, 32'hA5A5_A5A5);
        send_cmd(CMD_INS_POS, 6'd5, 32'h5A5A_5A5A);
        send_cmd(CMD_DEL_POS, 6'd4, 32'h0);
        send_cmd(CMD_DEL_POS, 6'd63, 32'h0);
        send_cmd(CMD_UNUSED_LO, 6'd0, 32'hDEAD_BEEF);
        send_cmd(CMD_UNUSED_HI, 6'd63, 32'hFFFF_FFFF);
        // Remove last and middle, insert one, then remove tail and head until empty
        send_cmd(CMD_DEL_POS, 6'd3, 32'h0);
        send_cmd(CMD_DEL_POS, 6'd1, 32'h0);
        send_cmd(CMD_INS_POS, 6'd1, 32'h0BAD_F00D);
        send_cmd(CMD_DEL_TAIL, 6'd0, 32'h0);
        send_cmd(CMD_DEL_HEAD, 6'd0, 32'h0);
        send_cmd(CMD_DEL_HEAD, 6'd0, 32'h0);
        send_cmd(CMD_DEL_TAIL, 6'd0, 32'h0);

        // Random phases with different idling on each side
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            send_random(PHASE_ITEMS);
        end

        // Long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b1;
        send_random(PRESSURE_ITEMS);
        s_tvalid <= 1'b0;

        // Drain and let the block settle
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.drain_check();

        $display("Covered %0d commands, %0d results: ok %0d, empty %0d, bad position %0d, full %0d",
                 sb.commands, sb.results, sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
                 sb.status_seen[ST_BADPOS], sb.status_seen[ST_FULL]);
        $display("Deepest list %0d of %0d nodes; receiver hold-off of %0d cycles served",
                 sb.deepest, DEPTH, hold_count);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: filelist.f
design/lle_pkg.sv
design/lle_ctrl.sv
design/lle_datapath.sv
design/linked_list_engine.sv
verif/linked_list_engine_test.sv
